[sv/rcpd_pkg.sv]
package rcpd_pkg;

  localparam int unsigned FIELD_BITS = 16;

  localparam logic [7:0] CH_LIVE = 8'h6F;
  localparam logic [7:0] CH_DEAD = 8'h62;
  localparam logic [7:0] CH_ROW  = 8'h24;
  localparam logic [7:0] CH_END  = 8'h21;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  typedef struct packed {
    logic                  emit;
    logic [FIELD_BITS-1:0] run_x;
    logic [FIELD_BITS-1:0] run_y;
    logic [FIELD_BITS-1:0] run_len;
    logic                  end_mark;
  } rcpd_result_t;

endpackage

[sv/rcpd_core.sv]
module rcpd_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           char_in,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output rcpd_pkg::rcpd_result_t res
);

  localparam int unsigned SUM_BITS = ((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS) + 2;
  localparam int unsigned CFG_BITS = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam int unsigned XW       = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned LW       = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned ACC_BITS = COUNT_BITS + 4;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint COORD_LO = -COORD_HI - 64'sd1;

  logic signed [COORD_BITS-1:0] origin_x_r, origin_x_nxt;
  logic signed [COORD_BITS-1:0] origin_y_r, origin_y_nxt;
  logic signed [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [COORD_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [COUNT_BITS-1:0]        pending_r, pending_nxt;
  logic                         present_r, present_nxt;
  logic                         finished_r, finished_nxt;

  logic [COUNT_BITS-1:0]        n;
  logic signed [SUM_BITS-1:0]   sum_x, sum_y;
  logic signed [COORD_BITS-1:0] adv_x, adv_y;
  logic [ACC_BITS-1:0]          acc;
  logic [COUNT_BITS-1:0]        acc_sat;
  logic signed [CFG_BITS-1:0]   cfg_wide;
  logic signed [COORD_BITS-1:0] cfg_clamped;
  logic signed [XW-1:0]         x_wide, y_wide;
  logic [LW-1:0]                n_wide;
  logic [15:0]                  len_sat;

  always_comb begin
    n     = present_r ? pending_r : COUNT_BITS'(1);
    sum_x = SUM_BITS'(cursor_x_r) + signed'(SUM_BITS'(n));
    sum_y = SUM_BITS'(cursor_y_r) + signed'(SUM_BITS'(n));
    adv_x = (sum_x > SUM_BITS'(COORD_HI)) ? COORD_BITS'(COORD_HI) : sum_x[COORD_BITS-1:0];
    adv_y = (sum_y > SUM_BITS'(COORD_HI)) ? COORD_BITS'(COORD_HI) : sum_y[COORD_BITS-1:0];

    acc = ({1'b0, pending_r, 3'b000} + {3'b000, pending_r, 1'b0})
          + ACC_BITS'(char_in[3:0]);
    acc_sat = (acc > ACC_BITS'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}} : acc[COUNT_BITS-1:0];

    cfg_wide    = CFG_BITS'(signed'(cfg_data));
    if (cfg_wide > CFG_BITS'(COORD_HI)) begin
      cfg_clamped = COORD_BITS'(COORD_HI);
    end else if (cfg_wide < CFG_BITS'(COORD_LO)) begin
      cfg_clamped = COORD_BITS'(COORD_LO);
    end else begin
      cfg_clamped = cfg_wide[COORD_BITS-1:0];
    end

    x_wide  = XW'(cursor_x_r);
    y_wide  = XW'(cursor_y_r);
    n_wide  = LW'(n);
    len_sat = (n_wide > LW'(16'hFFFF)) ? 16'hFFFF : n_wide[15:0];
  end

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    pending_nxt  = pending_r;
    present_nxt  = present_r;
    finished_nxt = finished_r;
    res          = '0;
    res.run_x    = x_wide[15:0];
    res.run_y    = y_wide[15:0];
    res.run_len  = len_sat;

    if (cfg_we) begin
      if (cfg_index == rcpd_pkg::CFG_ORIGIN_X) begin
        origin_x_nxt = cfg_clamped;
        cursor_x_nxt = cfg_clamped;
      end else begin
        origin_y_nxt = cfg_clamped;
        cursor_y_nxt = cfg_clamped;
      end
    end else if (step && !finished_r) begin
      case (char_in)
        rcpd_pkg::CH_LIVE: begin
          pending_nxt = '0;
          present_nxt = 1'b0;
          if (n != '0) begin
            res.emit     = 1'b1;
            cursor_x_nxt = adv_x;
          end
        end
        rcpd_pkg::CH_DEAD: begin
          pending_nxt  = '0;
          present_nxt  = 1'b0;
          cursor_x_nxt = adv_x;
        end
        rcpd_pkg::CH_ROW: begin
          pending_nxt  = '0;
          present_nxt  = 1'b0;
          cursor_x_nxt = origin_x_r;
          cursor_y_nxt = adv_y;
        end
        rcpd_pkg::CH_END: begin
          pending_nxt  = '0;
          present_nxt  = 1'b0;
          finished_nxt = 1'b1;
          res.emit     = 1'b1;
          res.run_x    = '0;
          res.run_y    = '0;
          res.run_len  = '0;
          res.end_mark = 1'b1;
        end
        default: begin
          if (char_in inside {[rcpd_pkg::CH_ZERO:rcpd_pkg::CH_NINE]}) begin
            pending_nxt = acc_sat;
            present_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      pending_r  <= '0;
      present_r  <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      pending_r  <= pending_nxt;
      present_r  <= present_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

[sv/rle_cell_pattern_decoder.sv]
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_char_in[7:0]
// out       out_valid / out_ready    out_run_x, out_run_y, out_run_len, out_end_mark
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data[15:0]
//
// One character item is accepted per cycle unless a held output register stalls the input;
// it is stored in the input register and its result, if any, in the output register.
// Decode state is registered in the core; throughput is one item per clock unless stalled.
// A held output register stalls the input register, which still takes one more item.
// Reset clears the origins, the cursor, the pending count and the end flag.
module rle_cell_pattern_decoder #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_run_x,
  output logic [15:0] out_run_y,
  output logic [15:0] out_run_len,
  output logic        out_end_mark,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic                   in_valid_r, in_valid_nxt;
  logic [7:0]             in_char_r;
  logic                   out_valid_r, out_valid_nxt;
  rcpd_pkg::rcpd_result_t out_r;
  rcpd_pkg::rcpd_result_t res;
  logic                   advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  rcpd_core #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .char_in  (in_char_r),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res      (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
    end
    if (advance && res.emit) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_run_x    = out_r.run_x;
  assign out_run_y    = out_r.run_y;
  assign out_run_len  = out_r.run_len;
  assign out_end_mark = out_r.end_mark;

endmodule

[tb/rcpd_run_checker.sv]
`timescale 1ns / 100ps
module rcpd_run_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_run_x,
  input  logic [15:0] out_run_y,
  input  logic [15:0] out_run_len,
  input  logic        out_end_mark,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked
);

  localparam int COORD_MAX = 32767;
  localparam int COUNT_MAX = 65535;

  typedef struct packed {
    logic [15:0] run_x;
    logic [15:0] run_y;
    logic [15:0] run_len;
    logic        end_mark;
  } pattern_run_t;

  pattern_run_t       expected_runs[$];
  logic signed [15:0] origin_col;
  logic signed [15:0] origin_row;
  logic signed [15:0] cursor_col;
  logic signed [15:0] cursor_row;
  logic [15:0]        run_count;
  logic               count_seen;
  logic               stopped;

  function automatic logic signed [15:0] advance_sat(input logic signed [15:0] base,
                                                    input logic [15:0] step);
    int sum;
    sum = int'(base) + int'(step);
    if (sum > COORD_MAX) begin
      sum = COORD_MAX;
    end
    return sum[15:0];
  endfunction

  function automatic void queue_run(input pattern_run_t run);
    expected_runs.insert(expected_runs.size(), run);
  endfunction

  task automatic decode_char(input logic [7:0] c);
    logic [15:0]  n;
    int           acc;
    pattern_run_t run;
    if (!stopped) begin
      if (c inside {[rcpd_pkg::CH_ZERO:rcpd_pkg::CH_NINE]}) begin
        acc = int'(run_count) * 10 + int'(c) - int'(rcpd_pkg::CH_ZERO);
        if (acc > COUNT_MAX) begin
          acc = COUNT_MAX;
        end
        run_count = acc[15:0];
        count_seen = 1'b1;
      end else if (c inside {rcpd_pkg::CH_LIVE, rcpd_pkg::CH_DEAD, rcpd_pkg::CH_ROW}) begin
        n = count_seen ? run_count : 16'd1;
        run_count = '0;
        count_seen = 1'b0;
        if (c == rcpd_pkg::CH_LIVE) begin
          if (n != 16'd0) begin
            run.run_x = cursor_col;
            run.run_y = cursor_row;
            run.run_len = n;
            run.end_mark = 1'b0;
            queue_run(run);
            cursor_col = advance_sat(cursor_col, n);
          end
        end else if (c == rcpd_pkg::CH_DEAD) begin
          cursor_col = advance_sat(cursor_col, n);
        end else begin
          cursor_col = origin_col;
          cursor_row = advance_sat(cursor_row, n);
        end
      end else if (c == rcpd_pkg::CH_END) begin
        run_count = '0;
        count_seen = 1'b0;
        stopped = 1'b1;
        run = '0;
        run.end_mark = 1'b1;
        queue_run(run);
      end
    end
  endtask

  task automatic check_result();
    pattern_run_t want;
    if (expected_runs.size() == 0) begin
      $error("Unexpected result item: run_x %0d run_y %0d run_len %0d end_mark %0d",
             $signed(out_run_x), $signed(out_run_y), out_run_len, out_end_mark);
      fail_count++;
    end else begin
      want = expected_runs.pop_front();
      results_checked++;
      if (out_run_x !== want.run_x) begin
        $error("run_x: expected %0d, actual %0d", $signed(want.run_x), $signed(out_run_x));
        fail_count++;
      end
      if (out_run_y !== want.run_y) begin
        $error("run_y: expected %0d, actual %0d", $signed(want.run_y), $signed(out_run_y));
        fail_count++;
      end
      if (out_run_len !== want.run_len) begin
        $error("run_len: expected %0d, actual %0d", want.run_len, out_run_len);
        fail_count++;
      end
      if (out_end_mark !== want.end_mark) begin
        $error("end_mark: expected %0d, actual %0d", want.end_mark, out_end_mark);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      origin_col = '0;
      origin_row = '0;
      cursor_col = '0;
      cursor_row = '0;
      run_count = '0;
      count_seen = 1'b0;
      stopped = 1'b0;
      expected_runs.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rcpd_pkg::CFG_ORIGIN_X) begin
          origin_col = cfg_data;
          cursor_col = cfg_data;
        end else begin
          origin_row = cfg_data;
          cursor_row = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        decode_char(in_char_in);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
    outstanding <= expected_runs.size();
  end

endmodule

[tb/tb_rle_cell_pattern_decoder.sv]
`timescale 1ns / 100ps
module tb_rle_cell_pattern_decoder;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_run_x;
  logic [15:0] out_run_y;
  logic [15:0] out_run_len;
  logic        out_end_mark;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int burst_left = 0;
  int chars_sent = 0;
  int origin_settings = 0;
  int stall_cycle = 0;

  always #4 clk = ~clk;

  rle_cell_pattern_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_run_x    (out_run_x),
    .out_run_y    (out_run_y),
    .out_run_len  (out_run_len),
    .out_end_mark (out_end_mark),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rcpd_run_checker u_run_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_run_x       (out_run_x),
    .out_run_y       (out_run_y),
    .out_run_len     (out_run_len),
    .out_end_mark    (out_end_mark),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= (stall_cycle[1:0] == 2'd0);
      default: out_ready <= stall_cycle[4];
    endcase
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic send_token();
    int          kind;
    int          digits;
    logic [7:0]  c;
    kind = $urandom_range(0, 99);
    if (kind < 82) begin
      digits = $urandom_range(0, 99);
      if (digits < 30) begin
        digits = 0;
      end else if (digits < 70) begin
        digits = 1;
      end else if (digits < 96) begin
        digits = $urandom_range(2, 3);
      end else begin
        digits = $urandom_range(5, 7);
      end
      repeat (digits) begin
        c = 8'($urandom_range(0, 9));
        send_char(c + rcpd_pkg::CH_ZERO);
        if ($urandom_range(0, 19) == 0) begin
          send_char(8'h20);
        end
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        send_char(rcpd_pkg::CH_LIVE);
      end else if (kind < 8) begin
        send_char(rcpd_pkg::CH_DEAD);
      end else begin
        send_char(rcpd_pkg::CH_ROW);
      end
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0:       send_char(8'h20);
        1:       send_char(8'h0A);
        2:       send_char(8'h0D);
        default: send_char(8'h09);
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
      if (c == rcpd_pkg::CH_END) begin
        c = 8'hA1;
      end
      send_char(c);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_origins(input logic [15:0] col, input logic [15:0] row);
    cfg_index <= rcpd_pkg::CFG_ORIGIN_X;
    cfg_data <= col;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= rcpd_pkg::CFG_ORIGIN_Y;
    cfg_data <= row;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    origin_settings++;
  endtask

  task automatic run_phase(input logic [15:0] col, input logic [15:0] row, input int count);
    int target;
    wait_idle();
    set_origins(col, row);
    target = chars_sent + count;
    while (chars_sent < target) send_token();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_in = '0;
    cfg_valid = 1'b0;
    cfg_index = rcpd_pkg::CFG_ORIGIN_X;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    send_text("o3ob0o0b2$0$1");
    send_char(8'hFF);
    send_text("2o");
    send_char(8'h00);
    send_text("9999999o$o");

    run_phase(16'h8000, 16'h7FFF, 95);
    run_phase(16'h7FFF, 16'h8000, 95);
    repeat (3) run_phase(16'($urandom), 16'($urandom), 95);
    run_phase(16'($urandom_range(0, 40)) - 16'd20, 16'($urandom_range(0, 40)) - 16'd20, 95);

    wait_idle();
    send_text("12!");
    repeat (10) send_char(8'($urandom_range(0, 255)));
    send_text("o!");
    wait_idle();
    repeat (20) @(negedge clk);

    $display("Sent %0d characters under %0d origin settings and checked %0d result items,",
             chars_sent, origin_settings + 1, results_checked);
    $display("covering counts, saturation, zero runs, ignored bytes and the end marker.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
sv/rcpd_pkg.sv
sv/rcpd_core.sv
sv/rle_cell_pattern_decoder.sv
tb/rcpd_run_checker.sv
tb/tb_rle_cell_pattern_decoder.sv
